FILE: rtl/fsvs_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fsvs_pkg
// Shared types and constants for the fair-share vruntime scheduler core.
// ---------------------------------------------------------------------------
package fsvs_pkg;

    localparam int MAX_TASKS_DEF        = 16;
    localparam int NICE_ZERO_WEIGHT_DEF = 1024;

    localparam int VR_W    = 31;
    localparam int ET_W    = 32;
    localparam int COUNT_W = 5;

    localparam logic [VR_W-1:0]    VR_TOP      = 31'h7FFF_FFFF;
    localparam logic [VR_W-1:0]    VR_CLAMP    = VR_TOP - 31'd1;
    localparam logic [VR_W-1:0]    VR_CLEAR_AT = VR_TOP - 31'd10;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd1;

    typedef struct packed {
        logic [3:0]  task_id;
        logic [19:0] run_ticks;
        logic [16:0] load_weight;
        logic [31:0] inverse_weight;
    } charge_t;

    typedef struct packed {
        logic [3:0]      next_task;
        logic [VR_W-1:0] task_vruntime;
        logic [VR_W-1:0] queue_min_vruntime;
        logic            period_cleared;
        logic [ET_W-1:0] task_exec_total;
    } result_t;

    // control from the sequencer to the task store
    typedef struct packed {
        logic vr_we;
        logic et_we;
        logic clear;
    } store_ctrl_t;

endpackage

FILE: rtl/fsvs_task_store.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fsvs_task_store
// Per-task virtual runtime and execution total memories, one read and one
// write port each, registered read, with per-entry valid bits for reset.
// ---------------------------------------------------------------------------
module fsvs_task_store #(
    parameter int MAX_TASKS = fsvs_pkg::MAX_TASKS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  fsvs_pkg::store_ctrl_t       ctrl,
    input  logic [$clog2(MAX_TASKS)-1:0] rd_addr,
    input  logic [$clog2(MAX_TASKS)-1:0] wr_addr,
    input  logic [fsvs_pkg::VR_W-1:0]   vr_wdata,
    input  logic [fsvs_pkg::ET_W-1:0]   et_wdata,
    output logic [fsvs_pkg::VR_W-1:0]   vr_rdata,
    output logic [fsvs_pkg::ET_W-1:0]   et_rdata
);

    logic [fsvs_pkg::VR_W-1:0] vr_mem [MAX_TASKS];
    logic [fsvs_pkg::ET_W-1:0] et_mem [MAX_TASKS];

    logic [MAX_TASKS-1:0]      vr_vld_reg;
    logic [MAX_TASKS-1:0]      et_vld_reg;
    logic [fsvs_pkg::VR_W-1:0] vr_rd_reg;
    logic [fsvs_pkg::ET_W-1:0] et_rd_reg;
    logic                      vr_rv_reg;
    logic                      et_rv_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.vr_we)
        begin
            vr_mem[wr_addr] <= vr_wdata;
        end
        if (ctrl.et_we)
        begin
            et_mem[wr_addr] <= et_wdata;
        end
        vr_rd_reg <= vr_mem[rd_addr];
        et_rd_reg <= et_mem[rd_addr];
        vr_rv_reg <= vr_vld_reg[rd_addr];
        et_rv_reg <= et_vld_reg[rd_addr];
    end

    // a period clear drops every runtime at once, totals are kept
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vr_vld_reg <= '0;
            et_vld_reg <= '0;
        end
        else
        begin
            if (ctrl.clear)
            begin
                vr_vld_reg <= '0;
            end
            else if (ctrl.vr_we)
            begin
                vr_vld_reg[wr_addr] <= 1'b1;
            end
            if (ctrl.et_we)
            begin
                et_vld_reg[wr_addr] <= 1'b1;
            end
        end
    end

    assign vr_rdata = vr_rv_reg ? vr_rd_reg : '0;
    assign et_rdata = et_rv_reg ? et_rd_reg : '0;

endmodule

FILE: rtl/fair_share_vruntime_scheduler_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fair_share_vruntime_scheduler_core
// Charges one task per transaction, updates its virtual runtime and total,
// and picks the active task with the least virtual runtime to run next.
// ---------------------------------------------------------------------------
// One charge transaction runs from acceptance to the next acceptance through
// the accepting state, a multiply state, a read-modify-write state on the task
// memories, then a minimum search that reads one stored runtime per cycle
// through the single read port of the runtime memory and then compares the
// last read and closes, and a final state that raises the queue minimum and
// loads the result register. That final state waits while an earlier result
// is still stalled. The result register lets the next charge be accepted while
// a result still waits. Reset needs no clearing pass: per-entry valid bits make
// every runtime and total read as zero.
module fair_share_vruntime_scheduler_core #(
    parameter int MAX_TASKS        = fsvs_pkg::MAX_TASKS_DEF,
    parameter int NICE_ZERO_WEIGHT = fsvs_pkg::NICE_ZERO_WEIGHT_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         charge_valid,
    output logic                         charge_stall,
    input  fsvs_pkg::charge_t            charge,
    output logic                         result_valid,
    input  logic                         result_stall,
    output fsvs_pkg::result_t            result,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [fsvs_pkg::COUNT_W-1:0] cfg_data
);

    localparam int IDX_W  = $clog2(MAX_TASKS);
    localparam int CNT_W  = $clog2(MAX_TASKS + 1);
    localparam int PROD_W = 52;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_UPD  = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0]                     state_reg, state_next;
    fsvs_pkg::charge_t              in_reg;
    logic [IDX_W-1:0]               id_reg, id_next;
    logic [PROD_W-1:0]              prod_reg;
    logic [fsvs_pkg::VR_W-1:0]      cvr_reg, cvr_next;
    logic [fsvs_pkg::ET_W-1:0]      et_reg, et_next;
    logic [IDX_W-1:0]               best_idx_reg, best_idx_next;
    logic [fsvs_pkg::VR_W:0]        best_val_reg, best_val_next;
    logic [CNT_W-1:0]               scan_idx_reg, scan_idx_next;
    logic [IDX_W-1:0]               cmp_idx_reg, cmp_idx_next;
    logic                           cmp_vld_reg, cmp_vld_next;
    logic [fsvs_pkg::VR_W-1:0]      min_reg, min_next;
    logic [fsvs_pkg::COUNT_W-1:0]   count_reg;
    logic                           out_valid_reg, out_valid_next;
    fsvs_pkg::result_t              out_reg, out_next;

    fsvs_pkg::store_ctrl_t          st_ctrl;
    logic [IDX_W-1:0]               rd_addr;
    logic [fsvs_pkg::VR_W-1:0]      vr_rdata;
    logic [fsvs_pkg::ET_W-1:0]      et_rdata;

    logic [CNT_W-1:0]               n_active;
    logic                           charged_act;
    logic                           accept;
    logic                           out_free;
    logic [31:0]                    mult;
    logic [fsvs_pkg::VR_W-1:0]      weighted;
    logic [fsvs_pkg::VR_W-1:0]      new_min;
    logic                           do_clear;

    // task index modulo the table depth, at most eight subtract steps
    function automatic logic [IDX_W-1:0] wrap_id(input logic [3:0] raw);
        logic [3:0] v;
        v = raw;
        for (int k = 0; k < 8; k++)
        begin
            if (32'(v) >= MAX_TASKS)
            begin
                v = v - 4'(MAX_TASKS);
            end
        end
        return IDX_W'(v);
    endfunction

    fsvs_task_store #(
        .MAX_TASKS (MAX_TASKS)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (st_ctrl),
        .rd_addr  (rd_addr),
        .wr_addr  (id_reg),
        .vr_wdata (cvr_next),
        .et_wdata (et_next),
        .vr_rdata (vr_rdata),
        .et_rdata (et_rdata)
    );

    assign charge_stall = (state_reg != S_IDLE);
    assign accept       = charge_valid && !charge_stall;
    assign cfg_ready    = 1'b1;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;
    assign out_free     = !out_valid_reg || !result_stall;

    always_comb
    begin
        if (count_reg == '0)
        begin
            n_active = CNT_W'(1);
        end
        else if (32'(count_reg) > MAX_TASKS)
        begin
            n_active = CNT_W'(MAX_TASKS);
        end
        else
        begin
            n_active = CNT_W'(count_reg);
        end
    end

    assign charged_act = (CNT_W'(id_reg) < n_active);

    always_comb
    begin
        if (in_reg.load_weight == 17'(NICE_ZERO_WEIGHT) || in_reg.inverse_weight == '0)
        begin
            mult = 32'(NICE_ZERO_WEIGHT);
        end
        else
        begin
            mult = in_reg.inverse_weight;
        end
    end

    assign weighted = (prod_reg > PROD_W'(fsvs_pkg::VR_TOP)) ? fsvs_pkg::VR_TOP
                                                             : prod_reg[fsvs_pkg::VR_W-1:0];
    assign new_min  = (best_val_reg[fsvs_pkg::VR_W-1:0] > min_reg)
                    ? best_val_reg[fsvs_pkg::VR_W-1:0] : min_reg;
    assign do_clear = (new_min >= fsvs_pkg::VR_CLEAR_AT);

    always_comb
    begin
        state_next     = state_reg;
        id_next        = id_reg;
        cvr_next       = cvr_reg;
        et_next        = et_reg;
        best_idx_next  = best_idx_reg;
        best_val_next  = best_val_reg;
        scan_idx_next  = scan_idx_reg;
        cmp_idx_next   = cmp_idx_reg;
        cmp_vld_next   = 1'b0;
        min_next       = min_reg;
        out_valid_next = out_valid_reg && result_stall;
        out_next       = out_reg;
        rd_addr        = id_reg;
        st_ctrl        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    id_next    = wrap_id(charge.task_id);
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = S_UPD;
            end
            S_UPD:
            begin
                // read data for the charged task is back, write it again
                et_next = et_rdata + 32'(in_reg.run_ticks);
                if ((fsvs_pkg::VR_TOP - vr_rdata) <= weighted)
                begin
                    cvr_next = fsvs_pkg::VR_CLAMP;
                end
                else
                begin
                    cvr_next = vr_rdata + weighted;
                end
                st_ctrl.vr_we = 1'b1;
                st_ctrl.et_we = 1'b1;
                if (charged_act)
                begin
                    best_idx_next = id_reg;
                    best_val_next = {1'b0, cvr_next};
                end
                else
                begin
                    // sentinel above any runtime so task zero takes over
                    best_idx_next = '0;
                    best_val_next = '1;
                end
                scan_idx_next = '0;
                state_next    = S_SCAN;
            end
            S_SCAN:
            begin
                rd_addr = scan_idx_reg[IDX_W-1:0];
                if (scan_idx_reg < n_active)
                begin
                    scan_idx_next = scan_idx_reg + CNT_W'(1);
                    cmp_idx_next  = scan_idx_reg[IDX_W-1:0];
                    cmp_vld_next  = 1'b1;
                end
                if (cmp_vld_reg && ({1'b0, vr_rdata} < best_val_reg))
                begin
                    best_idx_next = cmp_idx_reg;
                    best_val_next = {1'b0, vr_rdata};
                end
                if (scan_idx_reg == n_active && !cmp_vld_reg)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next          = 1'b1;
                    out_next.task_exec_total = et_reg;
                    if (do_clear)
                    begin
                        // every runtime reads zero, so the charged task wins the tie
                        st_ctrl.clear               = 1'b1;
                        min_next                    = '0;
                        out_next.next_task          = charged_act ? 4'(id_reg) : 4'd0;
                        out_next.task_vruntime      = '0;
                        out_next.queue_min_vruntime = '0;
                        out_next.period_cleared     = 1'b1;
                    end
                    else
                    begin
                        min_next                    = new_min;
                        out_next.next_task          = 4'(best_idx_reg);
                        out_next.task_vruntime      = cvr_reg;
                        out_next.queue_min_vruntime = new_min;
                        out_next.period_cleared     = 1'b0;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            scan_idx_reg  <= '0;
            cmp_vld_reg   <= 1'b0;
            min_reg       <= '0;
            count_reg     <= fsvs_pkg::COUNT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_idx_reg  <= scan_idx_next;
            cmp_vld_reg   <= cmp_vld_next;
            min_reg       <= min_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                count_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_reg <= charge;
        end
        if (state_reg == S_MUL)
        begin
            prod_reg <= PROD_W'(in_reg.run_ticks) * PROD_W'(mult);
        end
        id_reg       <= id_next;
        cvr_reg      <= cvr_next;
        et_reg       <= et_next;
        best_idx_reg <= best_idx_next;
        best_val_reg <= best_val_next;
        cmp_idx_reg  <= cmp_idx_next;
        out_reg      <= out_next;
    end

endmodule
